/* rtl/lagged_fibonacci_random_macros.svh */
// Assertion macros shared by the lagged Fibonacci generator RTL.
`ifndef LAGGED_FIBONACCI_RANDOM_MACROS_SVH
`define LAGGED_FIBONACCI_RANDOM_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define LFR_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LFR_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/lfr_pkg.sv */
// Package with types, constants and the control store of the lagged Fibonacci generator.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

    localparam int TABLE_LEN = 98;
    localparam int SHORT_LAG = 27;
    localparam int IDX_W     = 7;
    localparam int WORD_W    = 16;
    localparam int STEP_W    = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [STEP_W-1:0] step_t;

    // Reset contents of the lag table
    localparam word_t SEED_WORDS [TABLE_LEN] = '{
        16'o020651, 16'o147643, 16'o164707, 16'o125262, 16'o104256, 16'o074760,
        16'o114470, 16'o052607, 16'o045551, 16'o134031, 16'o024107, 16'o030766,
        16'o154073, 16'o114777, 16'o024540, 16'o111012, 16'o011042, 16'o104067,
        16'o056332, 16'o142244, 16'o131107, 16'o034074, 16'o052641, 16'o163046,
        16'o026303, 16'o131352, 16'o077724, 16'o002462, 16'o110775, 16'o127346,
        16'o020100, 16'o137011, 16'o136163, 16'o145552, 16'o144223, 16'o134111,
        16'o075001, 16'o075221, 16'o176705, 16'o000210, 16'o103625, 16'o120246,
        16'o062614, 16'o016147, 16'o054723, 16'o151200, 16'o105223, 16'o021001,
        16'o016224, 16'o073377, 16'o150716, 16'o014557, 16'o112613, 16'o037466,
        16'o002677, 16'o052542, 16'o063572, 16'o105462, 16'o106436, 16'o063302,
        16'o053171, 16'o133243, 16'o113130, 16'o123222, 16'o072371, 16'o041043,
        16'o163614, 16'o037432, 16'o147330, 16'o153403, 16'o130306, 16'o056455,
        16'o175640, 16'o120567, 16'o100601, 16'o042371, 16'o154635, 16'o051133,
        16'o074252, 16'o174525, 16'o163223, 16'o052022, 16'o022564, 16'o135512,
        16'o021760, 16'o006743, 16'o006451, 16'o067445, 16'o106210, 16'o025417,
        16'o066566, 16'o062723, 16'o124224, 16'o144643, 16'o164502, 16'o025342,
        16'o003521, 16'o024050
    };

    localparam idx_t LEAD_RESET = IDX_W'(TABLE_LEN - 1);
    localparam idx_t LAG_RESET  = IDX_W'((TABLE_LEN - 1 + SHORT_LAG) % TABLE_LEN);

    // Action codes
    localparam logic [1:0] ACT_RAW    = 2'd0;
    localparam logic [1:0] ACT_RANGE  = 2'd1;
    localparam logic [1:0] ACT_RESEED = 2'd2;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SPAN = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] range_low;
        logic signed [15:0] range_high;
        logic [15:0]        seed_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               status;
    } out_item_t;

    // Table port controls
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        word_t wr_data;
        logic  reseed_en;
        word_t seed;
    } tbl_ctl_t;

    // Remainder unit controls
    typedef struct packed {
        logic init;
        logic step;
    } rem_ctl_t;

    // Sequencer jump kinds
    typedef enum logic [2:0] {
        JMP_NEXT     = 3'd0,
        JMP_DISPATCH = 3'd1,
        JMP_IF_RAW   = 3'd2,
        JMP_LOOP     = 3'd3,
        JMP_GOTO     = 3'd4
    } jump_t;

    // Program step addresses
    localparam step_t STEP_FETCH    = 4'd0;
    localparam step_t STEP_ADVANCE  = 4'd1;
    localparam step_t STEP_RD_LAG   = 4'd2;
    localparam step_t STEP_RD_LEAD  = 4'd3;
    localparam step_t STEP_ADD_WR   = 4'd4;
    localparam step_t STEP_REM_INIT = 4'd5;
    localparam step_t STEP_REM_STEP = 4'd6;
    localparam step_t STEP_REM_FIX  = 4'd7;
    localparam step_t STEP_EMIT     = 4'd8;

    typedef struct packed {
        logic  wait_in;
        logic  wait_out;
        logic  adv_idx;
        logic  rd_lag;
        logic  rd_lead;
        logic  grab_lag;
        logic  add_wr;
        logic  rem_init;
        logic  rem_step;
        logic  rem_fix;
        jump_t jump;
        step_t target;
    } ucode_t;

    // Control store: one control word per program step
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        w.jump = JMP_NEXT;
        w.target = STEP_FETCH;
        unique case (step)
            STEP_FETCH: begin
                w.wait_in = 1'b1;
                w.jump    = JMP_DISPATCH;
            end
            STEP_ADVANCE:  w.adv_idx = 1'b1;
            STEP_RD_LAG:   w.rd_lag = 1'b1;
            STEP_RD_LEAD: begin
                w.rd_lead  = 1'b1;
                w.grab_lag = 1'b1;
            end
            STEP_ADD_WR: begin
                w.add_wr = 1'b1;
                w.jump   = JMP_IF_RAW;
                w.target = STEP_EMIT;
            end
            STEP_REM_INIT: w.rem_init = 1'b1;
            STEP_REM_STEP: begin
                w.rem_step = 1'b1;
                w.jump     = JMP_LOOP;
            end
            STEP_REM_FIX:  w.rem_fix = 1'b1;
            STEP_EMIT: begin
                w.wait_out = 1'b1;
                w.jump     = JMP_GOTO;
                w.target   = STEP_FETCH;
            end
            default: begin
                w.jump   = JMP_GOTO;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/lfr_table.sv */
// Lag table memory with reset-value fallback and a running reseed mask.
`timescale 1ns / 1ps
`default_nettype none
`include "lagged_fibonacci_random_macros.svh"

module lfr_table (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lfr_pkg::tbl_ctl_t ctl,
    output      lfr_pkg::word_t   rd_data
);
    import lfr_pkg::*;

    word_t                mem [TABLE_LEN];
    logic [TABLE_LEN-1:0] valid_reg;
    word_t                mask_reg;
    word_t                raw_reg;
    word_t                init_reg;
    logic                 hit_reg;

    // Store words under the current mask so a reseed is one register update
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data ^ mask_reg;
        end
    end

    // Register the read word with its written flag and reset word
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            raw_reg  <= mem[ctl.rd_addr];
            init_reg <= SEED_WORDS[ctl.rd_addr];
            hit_reg  <= valid_reg[ctl.rd_addr];
        end
    end

    // Track written entries and fold reseeds into the mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            mask_reg  <= '0;
        end else begin
            if (ctl.wr_en) begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.reseed_en) begin
                mask_reg <= mask_reg ^ ctl.seed;
            end
        end
    end

    assign rd_data = (hit_reg ? raw_reg : init_reg) ^ mask_reg;

    `LFR_ASSERT_IMPLY(a_wr_in_range, aclk, aresetn, ctl.wr_en, ctl.wr_addr < IDX_W'(TABLE_LEN), "table write address out of range")
    `LFR_ASSERT_IMPLY(a_rd_in_range, aclk, aresetn, ctl.rd_en, ctl.rd_addr < IDX_W'(TABLE_LEN), "table read address out of range")
    `LFR_ASSERT_IMPLY(a_reseed_alone, aclk, aresetn, ctl.reseed_en, !ctl.wr_en && !ctl.rd_en, "reseed overlaps a table access")

endmodule

`default_nettype wire

/* rtl/lfr_rem.sv */
// Restoring remainder unit: one quotient bit per cycle while step is asserted, over a 16-bit magnitude.
`timescale 1ns / 1ps
`default_nettype none

module lfr_rem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lfr_pkg::rem_ctl_t ctl,
    input  wire logic [15:0]       dividend,
    input  wire logic [16:0]       divisor,
    output      logic [15:0]       remainder,
    output      logic              last
);
    import lfr_pkg::*;

    logic [15:0] quo_reg;
    logic [15:0] rem_reg;
    logic [16:0] div_reg;
    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;

    // Shift in the next dividend bit and trial-subtract
    assign trial = {rem_reg, quo_reg[15]};
    assign fits  = trial >= div_reg;
    assign diff  = trial - div_reg;

    always_comb begin
        count_next = count_reg;
        if (ctl.init) begin
            count_next = 5'd16;
        end else if (ctl.step && count_reg != 5'd0) begin
            count_next = count_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Load operands on init, then advance one bit a cycle while step is asserted
    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (ctl.step) begin
            quo_reg <= {quo_reg[14:0], 1'b0};
            rem_reg <= fits ? diff[15:0] : trial[15:0];
        end
    end

    assign remainder = rem_reg;
    assign last      = count_reg == 5'd1;

endmodule

`default_nettype wire

/* rtl/lagged_fibonacci_random.sv */
// Top level of the additive lagged Fibonacci generator: microcoded sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "lagged_fibonacci_random_macros.svh"

// Channel   Ports                        Word
// input     s_valid, s_ready, s_data     action, range_low, range_high, seed_value
// result    m_valid, m_ready, m_data     value, status
//
// One word at a time runs through a 9-step control store. A raw draw makes
// two reads of the single table port, then an add and write back.
// A range draw goes on through remainder init, the bit-serial loop and a fix step.
// Reseed, inverted bounds and unused action go straight from fetch to emit.
// Reset restores the table through per-entry written flags; no clearing pass.
// A new word is taken while a result waits; the sequencer stalls at its emit step.

module lagged_fibonacci_random (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire lfr_pkg::in_item_t  s_data,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      lfr_pkg::out_item_t m_data
);
    import lfr_pkg::*;

    step_t     step_reg;
    step_t     step_next;
    ucode_t    cw;
    logic      s_accept;
    logic      out_free;
    logic      hold;
    logic      bad_span;

    logic [1:0] act_reg;
    word_t      lo_reg;
    word_t      hi_reg;
    idx_t       lead_reg;
    idx_t       lead_next;
    idx_t       lag_reg;
    idx_t       lag_next;
    word_t      operand_reg;
    word_t      res_val_reg;
    logic       res_status_reg;
    logic       neg_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    tbl_ctl_t    tbl_ctl;
    word_t       tbl_rd_data;
    rem_ctl_t    rem_ctl;
    logic [15:0] rem_out;
    logic        rem_last;
    word_t       sum;
    word_t       magnitude;
    logic [16:0] span;
    word_t       fixed_val;

    // Decode the current control word
    assign cw       = ucode_rom(step_reg);
    assign s_ready  = cw.wait_in;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hold     = (cw.wait_in && !s_accept) || (cw.wait_out && !out_free);
    assign bad_span = s_data.range_high < s_data.range_low;

    // Sequence the program
    always_comb begin
        step_next = step_reg;
        if (!hold) begin
            unique case (cw.jump)
                JMP_NEXT: step_next = step_reg + 4'd1;
                JMP_DISPATCH: begin
                    priority if (s_data.action == ACT_RAW) begin
                        step_next = STEP_ADVANCE;
                    end else if (s_data.action == ACT_RANGE && !bad_span) begin
                        step_next = STEP_ADVANCE;
                    end else begin
                        step_next = STEP_EMIT;
                    end
                end
                JMP_IF_RAW: step_next = (act_reg == ACT_RAW) ? cw.target : step_reg + 4'd1;
                JMP_LOOP:   step_next = rem_last ? step_reg + 4'd1 : step_reg;
                JMP_GOTO:   step_next = cw.target;
                default:    step_next = STEP_FETCH;
            endcase
        end
    end

    // Advance both indices, wrapping at the end of the table
    always_comb begin
        lead_next = lead_reg;
        lag_next  = lag_reg;
        if (cw.adv_idx) begin
            lead_next = (lead_reg >= IDX_W'(TABLE_LEN - 1)) ? '0 : lead_reg + 1'b1;
            lag_next  = (lag_reg >= IDX_W'(TABLE_LEN - 1)) ? '0 : lag_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
            lead_reg <= LEAD_RESET;
            lag_reg  <= LAG_RESET;
        end else begin
            step_reg <= step_next;
            lead_reg <= lead_next;
            lag_reg  <= lag_next;
        end
    end

    // Drive the table port
    always_comb begin
        tbl_ctl           = '0;
        tbl_ctl.rd_en     = cw.rd_lag || cw.rd_lead;
        tbl_ctl.rd_addr   = cw.rd_lead ? lead_reg : lag_reg;
        tbl_ctl.wr_en     = cw.add_wr;
        tbl_ctl.wr_addr   = lead_reg;
        tbl_ctl.wr_data   = sum;
        tbl_ctl.reseed_en = s_accept && s_data.action == ACT_RESEED;
        tbl_ctl.seed      = s_data.seed_value;
    end

    lfr_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (tbl_ctl),
        .rd_data (tbl_rd_data)
    );

    // Draw sum and range draw arithmetic
    assign sum       = tbl_rd_data + operand_reg;
    assign magnitude = res_val_reg[15] ? (~res_val_reg + 16'd1) : res_val_reg;
    assign span      = {hi_reg[15], hi_reg} - {lo_reg[15], lo_reg} + 17'd1;
    assign fixed_val = (neg_reg && rem_out != 16'd0) ? (hi_reg + 16'd1 - rem_out)
                                                     : (lo_reg + rem_out);

    assign rem_ctl.init = cw.rem_init;
    assign rem_ctl.step = cw.rem_step;

    lfr_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (rem_ctl),
        .dividend  (magnitude),
        .divisor   (span),
        .remainder (rem_out),
        .last      (rem_last)
    );

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg        <= s_data.action;
            lo_reg         <= s_data.range_low;
            hi_reg         <= s_data.range_high;
            res_val_reg    <= '0;
            res_status_reg <= (s_data.action == ACT_RANGE && bad_span) ? STATUS_BAD_SPAN
                                                                       : STATUS_OK;
        end
        if (cw.grab_lag) begin
            operand_reg <= tbl_rd_data;
        end
        if (cw.add_wr) begin
            res_val_reg <= sum;
        end
        if (cw.rem_init) begin
            neg_reg <= res_val_reg[15];
        end
        if (cw.rem_fix) begin
            res_val_reg <= fixed_val;
        end
    end

    // Output register: load at the emit step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cw.wait_out && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.wait_out && out_free) begin
            m_data_reg.value  <= res_val_reg;
            m_data_reg.status <= res_status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LFR_ASSERT_ALWAYS(a_lag_spacing, aclk, aresetn, (8'(lag_reg) == 8'(lead_reg) + 8'(SHORT_LAG)) || (8'(lag_reg) + 8'(TABLE_LEN - SHORT_LAG) == 8'(lead_reg)), "lead and lag indices lost their spacing")
    `LFR_ASSERT_ALWAYS(a_step_bound, aclk, aresetn, step_reg <= STEP_EMIT, "sequencer left its program")
    `LFR_ASSERT_IMPLY(a_emit_source, aclk, aresetn, $rose(m_valid_reg), $past(step_reg) == STEP_EMIT, "result raised outside the emit step")

endmodule

`default_nettype wire

/* tb/lfr_result_checker.sv */
// Checker for the lagged Fibonacci generator: tracks generator state and scores each result word.
`timescale 1ns / 1ps

module lfr_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  lfr_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  lfr_pkg::out_item_t  m_data,
    output int                  fail_count,
    output int                  pending_count
);
    import lfr_pkg::*;

    word_t       fib_table [TABLE_LEN];
    int unsigned lead_pos;
    int unsigned lag_pos;
    out_item_t   expected_q [$];

    // Step an index to the next table entry, wrapping at the end
    function automatic int unsigned wrap_next(int unsigned pos);
        return (pos >= TABLE_LEN - 1) ? 0 : pos + 1;
    endfunction

    // Advance both indices and fold the lagged entry into the lead entry
    function automatic logic signed [15:0] advance_generator();
        lead_pos = wrap_next(lead_pos);
        lag_pos  = wrap_next(lag_pos);
        fib_table[lead_pos] = fib_table[lead_pos] + fib_table[lag_pos];
        return fib_table[lead_pos];
    endfunction

    // Work out the result word for one input word and update the generator
    function automatic out_item_t predict_word(in_item_t w);
        out_item_t          r;
        int                 span;
        int                 rem;
        logic signed [15:0] drawn;
        r.value  = '0;
        r.status = STATUS_OK;
        case (w.action)
            ACT_RAW: begin
                r.value = advance_generator();
            end
            ACT_RANGE: begin
                if (w.range_high < w.range_low) begin
                    // inverted bounds: no draw, no index movement
                    r.status = STATUS_BAD_SPAN;
                end else begin
                    span  = int'(w.range_high) - int'(w.range_low) + 1;
                    drawn = advance_generator();
                    rem   = int'(drawn) % span;
                    // fold negative remainders back from the top of the range
                    r.value = (rem < 0) ? 16'(rem + int'(w.range_high) + 1)
                                        : 16'(rem + int'(w.range_low));
                end
            end
            ACT_RESEED: begin
                foreach (fib_table[t]) fib_table[t] = fib_table[t] ^ w.seed_value;
            end
            default: begin
                // unused action: state untouched, zero result
            end
        endcase
        return r;
    endfunction

    // Score result words against the oldest expectation, then queue new ones
    always @(posedge aclk) begin : score
        out_item_t want;
        if (!aresetn) begin
            foreach (fib_table[t]) fib_table[t] = SEED_WORDS[t];
            lead_pos   = 32'(LEAD_RESET);
            lag_pos    = 32'(LAG_RESET);
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing expected: value %0d status %0d",
                             $time, $signed(m_data.value), m_data.status);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.value !== want.value) begin
                        fail_count++;
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, $signed(want.value), $signed(m_data.value));
                    end
                    if (m_data.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_word(s_data));
            end
        end
        pending_count = expected_q.size();
    end

endmodule

/* tb/tb_lagged_fibonacci_random.sv */
// Testbench top for the lagged Fibonacci generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lagged_fibonacci_random;
    import lfr_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_WORDS  = 200;
    localparam int         PHASES       = 4;
    localparam int         DRAIN_CYCLES = 30;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int   check_fails;
    int   words_pending;
    logic no_idle;
    logic hold_req;

    always #6 aclk = ~aclk;

    lagged_fibonacci_random dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    lfr_result_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (check_fails),
        .pending_count (words_pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (no_idle) return 0;
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic in_item_t make_word(logic [1:0] act, int lo, int hi, logic [15:0] seed);
        in_item_t w;
        w.action     = act;
        w.range_low  = 16'(lo);
        w.range_high = 16'(hi);
        w.seed_value = seed;
        return w;
    endfunction

    function automatic int rand_s16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Build one random word, weighted toward draws with varied bounds
    function automatic in_item_t random_word();
        int unsigned roll;
        int          lo;
        int          hi;
        int          swap;
        logic [1:0]  act;
        roll = $urandom_range(99);
        lo   = rand_s16();
        hi   = rand_s16();
        if (roll < 40) begin
            act = ACT_RAW;
        end else if (roll < 82) begin
            act = ACT_RANGE;
            case ($urandom_range(3))
                0: ;
                1: begin
                    hi = lo + int'($urandom_range(20));
                    if (hi > 32767) hi = 32767;
                end
                2: begin
                    if ($urandom_range(1)) lo = -32768;
                    if ($urandom_range(1)) hi = 32767;
                end
                default: hi = lo;
            endcase
            // order the bounds
            if (hi < lo) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
        end else if (roll < 90) begin
            act = ACT_RESEED;
        end else if (roll < 96) begin
            // inverted bounds: high strictly below low
            act = ACT_RANGE;
            lo  = int'($urandom_range(65534)) - 32767;
            hi  = -32768 + int'($urandom_range(lo + 32767));
        end else begin
            act = ACT_UNUSED;
        end
        return make_word(act, lo, hi, 16'($urandom));
    endfunction

    // Offer one word after a gap and hold it until accepted
    task automatic send_word(in_item_t w, int unsigned gap);
        if (gap != 0) begin
            s_valid = 1'b0;
            s_data  = in_item_t'({$urandom, $urandom});
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Pause the sender until every expected result word is back
    task automatic drain();
        s_valid = 1'b0;
        while (words_pending != 0) @(negedge aclk);
    endtask

    task automatic send_directed();
        send_word(make_word(ACT_RAW, 0, 0, 16'h0000), pick_gap());
        send_word(make_word(ACT_RAW, -1, -1, 16'hFFFF), pick_gap());
        send_word(make_word(ACT_RAW, 0, 0, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, -32768, 32767, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, 0, 0, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, -32768, -32768, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, 32767, 32767, 16'hFFFF), pick_gap());
        send_word(make_word(ACT_RANGE, -5, 5, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, 100, 200, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, -200, -100, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, 32767, -32768, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, 1, 0, 16'hFFFF), pick_gap());
        send_word(make_word(ACT_RESEED, 0, 0, 16'hFFFF), pick_gap());
        send_word(make_word(ACT_RAW, 0, 0, 16'h0000), pick_gap());
        send_word(make_word(ACT_RAW, 0, 0, 16'h0000), pick_gap());
        send_word(make_word(ACT_RESEED, -1, -1, 16'h0000), pick_gap());
        send_word(make_word(ACT_RESEED, 0, 0, 16'h5A5A), pick_gap());
        send_word(make_word(ACT_UNUSED, -32768, 32767, 16'hFFFF), pick_gap());
        send_word(make_word(ACT_UNUSED, 32767, -32768, 16'h0000), pick_gap());
        send_word(make_word(ACT_RANGE, -32768, 32767, 16'hA5A5), pick_gap());
        send_word(make_word(ACT_RANGE, -32768, -32767, 16'h0000), pick_gap());
        send_word(make_word(ACT_RAW, 0, 0, 16'h0000), pick_gap());
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int unsigned stall;
        logic        held;
        m_ready = 1'b0;
        held    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held    = 1'b1;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = pick_gap();
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Stop a hung run
    initial begin : watchdog
        #10ms;
        $display("** lagged_fibonacci_random: FAILED **");
        $finish;
    end

    initial begin : stimulus
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        send_directed();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // phase 2 runs with no idling on either side
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 1 && i == 50) hold_req = 1'b1;
                // keep offering back to back while the receiver holds off
                if (p == 1 && i >= 50 && i < 80) send_word(random_word(), 0);
                else send_word(random_word(), pick_gap());
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (check_fails == 0 && words_pending == 0) begin
            $display("** lagged_fibonacci_random: PASSED **");
        end else begin
            $display("** lagged_fibonacci_random: FAILED **");
        end
        $finish;
    end

endmodule
